@@ design/gne_pkg.sv @@
`timescale 1ns / 1ps

package gne_pkg;

  localparam int unsigned DEF_MAX_COLS = 64;
  localparam int unsigned DEF_MAX_ROWS = 64;

  localparam int unsigned COORD_W   = 7;
  localparam int unsigned CELL_W    = 6;
  localparam int unsigned NODE_W    = 12;
  localparam int unsigned COST_W    = 8;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 7;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [COST_W-1:0] COST_ORTHO = 8'd100;
  localparam logic [COST_W-1:0] COST_DIAG  = 8'd141;

  localparam logic OP_EXPAND = 1'b0;
  localparam logic OP_SET    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 8'd1;

  localparam logic [CFG_DAT_W-1:0] GRID_SIZE_RST = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               use_width;
  } mac_req_t;

  typedef struct packed {
    logic signed [1:0] dx;
    logic signed [1:0] dy;
  } step_t;

  function automatic step_t cand_step(input logic [2:0] k);
    step_t s;
    case (k)
      3'd0:    begin s.dx = 2'sb01; s.dy = 2'sb00; end
      3'd1:    begin s.dx = 2'sb00; s.dy = 2'sb01; end
      3'd2:    begin s.dx = 2'sb11; s.dy = 2'sb00; end
      3'd3:    begin s.dx = 2'sb00; s.dy = 2'sb11; end
      3'd4:    begin s.dx = 2'sb01; s.dy = 2'sb01; end
      3'd5:    begin s.dx = 2'sb11; s.dy = 2'sb01; end
      3'd6:    begin s.dx = 2'sb11; s.dy = 2'sb11; end
      3'd7:    begin s.dx = 2'sb01; s.dy = 2'sb11; end
      default: begin s.dx = 2'sb00; s.dy = 2'sb00; end
    endcase
    return s;
  endfunction

endpackage

@@ design/gne_tile_mem.sv @@
`timescale 1ns / 1ps

module gne_tile_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic          wdata_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/gne_mac.sv @@
`timescale 1ns / 1ps

module gne_mac
  import gne_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned OW       = 7,
  parameter int unsigned PW       = 15
) (
  input  mac_req_t        req_i,
  input  logic [OW-1:0]   grid_w_i,
  output logic [PW-1:0]   res_o
);

  logic [OW-1:0] mult;

  assign mult  = req_i.use_width ? grid_w_i : OW'(MAX_COLS);
  assign res_o = PW'(req_i.row) * PW'(mult) + PW'(req_i.col);

endmodule

@@ design/grid_neighbor_expansion_unit.sv @@
`timescale 1ns / 1ps

// Grid neighbor expansion. Holds one blocking bit per tile and, for an expand
// item, streams the free in-bounds neighbors of a cell: orthogonals (+x, +y,
// -x, -y) at cost 100, then diagonals at cost 141 where both flanking
// orthogonals are free; tlast marks the final result and tuser flags the
// single result of an expansion that found nothing. After reset the tile map
// is swept to zero, during which no item is taken. Items are handled one at
// a time by a sequencer around one shared multiply-add unit and a single-port
// tile memory: a set-tile item writes its tile in the set state (skipped when
// the cell is outside the grid); an expand item steps through the neighbor
// candidates, each one that passes the bounds and flank checks going through
// an address state, then a memory read state, and ends in a done state (at
// once for a cell outside the grid); it waits while the output is stalled.
module grid_neighbor_expansion_unit
  import gne_pkg::*;
#(
  parameter int unsigned MAX_COLS = DEF_MAX_COLS,
  parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // [5:0] cell_x, [11:6] cell_y, [12] block_value
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] opcode
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // [11:0] neighbor_node, [19:12] step_cost
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // [0] none_found
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OW    = ($clog2(MAX_COLS + 1) > COORD_W) ?
                                  $clog2(MAX_COLS + 1) : COORD_W;
  localparam int unsigned RW    = ($clog2(MAX_ROWS + 1) > COORD_W) ?
                                  $clog2(MAX_ROWS + 1) : COORD_W;
  localparam int unsigned PW    = COORD_W + OW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_CAND,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [CFG_DAT_W-1:0] grid_w_q, grid_h_q;
  logic [OW-1:0]        w;
  logic [RW-1:0]        h;

  logic [CELL_W-1:0] cx_q, cy_q;
  logic              bv_q;
  logic [2:0]        k_q;
  logic [3:0]        ok_q;
  logic [AW-1:0]     clr_q;

  logic              pend_valid_q;
  logic [NODE_W-1:0] pend_node_q;
  logic [COST_W-1:0] pend_cost_q;

  logic              m_valid_q;
  logic [NODE_W-1:0] m_node_q;
  logic [COST_W-1:0] m_cost_q;
  logic              m_none_q;
  logic              m_last_q;

  logic [CELL_W-1:0] in_x, in_y;
  logic              in_op, in_bv, in_inside, accept, out_free;
  logic              out_load;

  step_t             stp;
  logic [7:0]        nx8, ny8;
  logic              inb, eligible, last_cand;
  logic [COST_W-1:0] cand_cost;

  mac_req_t          mac_req;
  logic [PW-1:0]     mac_res;

  logic              mem_we, mem_re, mem_wdata, mem_rdata;
  logic [AW-1:0]     mem_addr;

  assign w = (grid_w_q == '0) ? OW'(1) :
             (OW'(grid_w_q) > OW'(MAX_COLS)) ? OW'(MAX_COLS) : OW'(grid_w_q);
  assign h = (grid_h_q == '0) ? RW'(1) :
             (RW'(grid_h_q) > RW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(grid_h_q);

  assign in_x  = s_axis_tdata_i[5:0];
  assign in_y  = s_axis_tdata_i[11:6];
  assign in_bv = s_axis_tdata_i[12];
  assign in_op = s_axis_tuser_i;
  assign in_inside = (OW'(in_x) < w) && (RW'(in_y) < h);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign out_load = out_free &&
                    (((state_q == ST_READ) && !mem_rdata && pend_valid_q) ||
                     (state_q == ST_DONE));

  assign stp = cand_step(k_q);
  assign nx8 = {2'b00, cx_q} + {{6{stp.dx[1]}}, stp.dx};
  assign ny8 = {2'b00, cy_q} + {{6{stp.dy[1]}}, stp.dy};
  assign inb = !nx8[7] && !ny8[7] && (OW'(nx8[6:0]) < w) && (RW'(ny8[6:0]) < h);
  assign eligible = k_q[2] ? (inb && ok_q[k_q[1:0]] && ok_q[k_q[1:0] + 2'd1]) : inb;
  assign last_cand = (k_q == 3'd7);
  assign cand_cost = k_q[2] ? COST_DIAG : COST_ORTHO;

  always_comb begin
    mac_req.row       = (state_q == ST_SET) ? COORD_W'(cy_q) : ny8[6:0];
    mac_req.col       = (state_q == ST_SET) ? COORD_W'(cx_q) : nx8[6:0];
    mac_req.use_width = (state_q == ST_READ);
  end

  gne_mac #(
    .MAX_COLS (MAX_COLS),
    .OW       (OW),
    .PW       (PW)
  ) u_mac (
    .req_i    (mac_req),
    .grid_w_i (w),
    .res_o    (mac_res)
  );

  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_SET);
  assign mem_re    = (state_q == ST_CAND) && eligible;
  assign mem_wdata = (state_q == ST_SET) ? bv_q : 1'b0;
  assign mem_addr  = (state_q == ST_CLEAR) ? clr_q : mac_res[AW-1:0];

  gne_tile_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_tile_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_w_q <= GRID_SIZE_RST;
      grid_h_q <= GRID_SIZE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IDX_WIDTH) begin
        grid_w_q <= cfg_data_i;
      end else if (cfg_index_i == CFG_IDX_HEIGHT) begin
        grid_h_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      k_q          <= '0;
      ok_q         <= '0;
      pend_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cx_q         <= in_x;
            cy_q         <= in_y;
            bv_q         <= in_bv;
            k_q          <= '0;
            ok_q         <= '0;
            pend_valid_q <= 1'b0;
            if (in_op == OP_SET) begin
              state_q <= in_inside ? ST_SET : ST_IDLE;
            end else begin
              state_q <= in_inside ? ST_CAND : ST_DONE;
            end
          end
        end
        ST_SET: begin
          state_q <= ST_IDLE;
        end
        ST_CAND: begin
          if (eligible) begin
            state_q <= ST_READ;
          end else if (last_cand) begin
            state_q <= ST_DONE;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_READ: begin
          if (mem_rdata) begin
            if (last_cand) begin
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_CAND;
            end
          end else if (out_free) begin
            if (pend_valid_q) begin
              m_node_q  <= pend_node_q;
              m_cost_q  <= pend_cost_q;
              m_none_q  <= 1'b0;
              m_last_q  <= 1'b0;
            end
            pend_valid_q <= 1'b1;
            pend_node_q  <= mac_res[NODE_W-1:0];
            pend_cost_q  <= cand_cost;
            if (!k_q[2]) begin
              ok_q[k_q[1:0]] <= 1'b1;
            end
            if (last_cand) begin
              state_q <= ST_DONE;
            end else begin
              k_q     <= k_q + 3'd1;
              state_q <= ST_CAND;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_last_q     <= 1'b1;
            m_node_q     <= pend_valid_q ? pend_node_q : '0;
            m_cost_q     <= pend_valid_q ? pend_cost_q : '0;
            m_none_q     <= !pend_valid_q;
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W - NODE_W - COST_W){1'b0}}, m_cost_q, m_node_q};
  assign m_axis_tuser_o  = m_none_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule
